// ===== sv/led_pattern_generator_assert.svh =====
// Assertion macros for the LED pattern generator checker.
// Used by lpg_checker.sv; no other dependencies.
`ifndef LED_PATTERN_GENERATOR_ASSERT_SVH
`define LED_PATTERN_GENERATOR_ASSERT_SVH

// Same-cycle implication under synchronous active-low reset.
`define LPG_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under synchronous active-low reset.
`define LPG_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/lpg_pkg.sv =====
// Shared types, codes, constants and the sine table for the LED pattern generator.
// No dependencies.
package lpg_pkg;

    localparam int LED_COUNT_DEF = 8;
    localparam int PHASES        = 24;
    localparam int NUM_PROGRAMS  = 7;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 28;

    localparam logic [11:0] FULL_DUTY      = 12'd2048;
    localparam logic [6:0]  MAX_BRIGHTNESS = 7'd100;
    localparam logic [27:0] PROGRAM_MAP_RST = 28'd88753745;
    // ceil(2^21 / 25): on = (b * 2048) / 100 = (b * ON_RECIP) >> 12 for b <= 100
    localparam logic [16:0] ON_RECIP       = 17'd83887;
    localparam logic [4:0]  LAST_PHASE     = 5'(PHASES - 1);

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_SET     = 2'd1;
    localparam logic [1:0] OP_PROGRAM = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROGRAM_MAP = 2'd1;

    localparam logic [3:0] MODE_OFF       = 4'd0;
    localparam logic [3:0] MODE_ON        = 4'd1;
    localparam logic [3:0] MODE_BLINK     = 4'd2;
    localparam logic [3:0] MODE_INV_BLINK = 4'd3;
    localparam logic [3:0] MODE_FAST      = 4'd4;
    localparam logic [3:0] MODE_SLOW      = 4'd5;
    localparam logic [3:0] MODE_DOUBLE    = 4'd6;
    localparam logic [3:0] MODE_TRIPLE    = 4'd7;
    localparam logic [3:0] MODE_BREATHE   = 4'd8;
    localparam logic [3:0] MODE_HEART     = 4'd9;
    localparam logic [3:0] MODE_STROBE    = 4'd10;

    localparam logic [2:0] PROG_INVALID = 3'(NUM_PROGRAMS);

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] led_index;
        logic [3:0] mode;
        logic [2:0] program_req;
    } lpg_in_t;

    typedef struct packed {
        logic [2:0]  led_number;
        logic [11:0] duty;
        logic        last;
    } lpg_out_t;

    typedef struct packed {
        logic [11:0] on_duty;
        logic [27:0] program_map;
    } lpg_cfg_t;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } lpg_state_t;

    function automatic logic [16:0] sine_lut(input logic [4:0] p);
        logic [16:0] v;
        case (p)
            5'd0:    v = 17'd32768;
            5'd1:    v = 17'd41249;
            5'd2:    v = 17'd49152;
            5'd3:    v = 17'd55938;
            5'd4:    v = 17'd61146;
            5'd5:    v = 17'd64419;
            5'd6:    v = 17'd65536;
            5'd7:    v = 17'd64419;
            5'd8:    v = 17'd61146;
            5'd9:    v = 17'd55938;
            5'd10:   v = 17'd49152;
            5'd11:   v = 17'd41249;
            5'd12:   v = 17'd32768;
            5'd13:   v = 17'd24287;
            5'd14:   v = 17'd16384;
            5'd15:   v = 17'd9598;
            5'd16:   v = 17'd4390;
            5'd17:   v = 17'd1117;
            5'd18:   v = 17'd0;
            5'd19:   v = 17'd1117;
            5'd20:   v = 17'd4390;
            5'd21:   v = 17'd9598;
            5'd22:   v = 17'd16384;
            5'd23:   v = 17'd24287;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/led_pattern_generator.sv =====
// LED pattern generator top level: sequencer, phase and mode state, result register.
// Depends on lpg_pkg, lpg_cfg_regs and lpg_duty_unit.
//
//   port group   dir   handshake             payload
//   s_*          in    s_valid / s_ready     lpg_in_t  (op, led_index, mode, program_req)
//   m_*          out   m_valid / m_ready     lpg_out_t (led_number, duty, last)
//   cfg_*        in    cfg_valid / cfg_ready cfg_index, cfg_data
//
// A tick or program item makes one pass of the shared duty unit per LED after it is
// accepted; a set item makes a single pass, for its own LED.
// Each pass waits while the result register is full and m_ready is low.
// The next item is accepted once the last result has entered the result register.
// Reset is synchronous, active low; it clears phase and modes and restores the
// configuration defaults. Items that cause no result are accepted and dropped.
module led_pattern_generator #(
    parameter int LED_COUNT = lpg_pkg::LED_COUNT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  lpg_pkg::lpg_in_t               s_payload,
    output logic                           m_valid,
    input  logic                           m_ready,
    output lpg_pkg::lpg_out_t              m_payload,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lpg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lpg_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam logic [3:0] LED_LIMIT = 4'(LED_COUNT);
    localparam logic [2:0] LAST_LED  = 3'(LED_COUNT - 1);

    lpg_pkg::lpg_cfg_t   cfg;
    lpg_pkg::lpg_state_t state_reg, state_next;
    logic [4:0]          phase_reg, phase_next;
    logic [3:0]          led_mode_reg [LED_COUNT];
    logic [3:0]          led_mode_next [LED_COUNT];
    logic [2:0]          cnt_reg, cnt_next;
    logic                single_reg, single_next;
    logic                m_valid_reg, m_valid_next;
    lpg_pkg::lpg_out_t   out_reg, out_next;
    logic                accept, item_ok, out_load, last_res;
    logic [3:0]          prog_mode, cur_mode;
    logic [11:0]         cur_duty;

    lpg_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_out   (cfg)
    );

    assign cur_mode  = led_mode_reg[cnt_reg[IDX_W-1:0]];
    assign prog_mode = cfg.program_map[5'({s_payload.program_req, 2'b00}) +: 4];

    lpg_duty_unit u_duty (
        .mode    (cur_mode),
        .phase   (phase_reg),
        .on_duty (cfg.on_duty),
        .duty    (cur_duty)
    );

    always_comb begin
        unique case (s_payload.op)
            lpg_pkg::OP_TICK:    item_ok = 1'b1;
            lpg_pkg::OP_SET:     item_ok = ({1'b0, s_payload.led_index} < LED_LIMIT);
            lpg_pkg::OP_PROGRAM: item_ok = (s_payload.program_req < lpg_pkg::PROG_INVALID);
            default:             item_ok = 1'b0;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_ready  = (state_reg == lpg_pkg::ST_IDLE);
        accept   = s_ready && s_valid;
        out_load = (state_reg == lpg_pkg::ST_EMIT) && (!m_valid_reg || m_ready);
        last_res = single_reg || (cnt_reg == LAST_LED);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lpg_pkg::ST_IDLE: begin
                if (accept && item_ok) state_next = lpg_pkg::ST_EMIT;
            end
            lpg_pkg::ST_EMIT: begin
                if (out_load && last_res) state_next = lpg_pkg::ST_IDLE;
            end
            default: state_next = lpg_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        single_next   = single_reg;
        led_mode_next = led_mode_reg;
        if (accept && item_ok) begin
            cnt_next    = 3'd0;
            single_next = 1'b0;
            case (s_payload.op)
                lpg_pkg::OP_TICK: begin
                    phase_next = (phase_reg == lpg_pkg::LAST_PHASE) ? 5'd0 : phase_reg + 5'd1;
                end
                lpg_pkg::OP_SET: begin
                    cnt_next    = s_payload.led_index;
                    single_next = 1'b1;
                    led_mode_next[s_payload.led_index[IDX_W-1:0]] = s_payload.mode;
                end
                default: begin
                    for (int i = 0; i < LED_COUNT; i++) led_mode_next[i] = prog_mode;
                end
            endcase
        end else if (out_load && !last_res) begin
            cnt_next = cnt_reg + 3'd1;
        end
    end

    always_comb begin
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        if (out_load) begin
            out_next.led_number = cnt_reg;
            out_next.duty       = cur_duty;
            out_next.last       = last_res;
            m_valid_next        = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lpg_pkg::ST_IDLE;
            phase_reg   <= 5'd0;
            cnt_reg     <= 3'd0;
            single_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < LED_COUNT; i++) led_mode_reg[i] <= lpg_pkg::MODE_OFF;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            single_reg   <= single_next;
            m_valid_reg  <= m_valid_next;
            led_mode_reg <= led_mode_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

endmodule

// ===== sv/lpg_cfg_regs.sv =====
// Configuration registers: on duty derived from brightness, and the program map.
// Depends on lpg_pkg.
module lpg_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lpg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lpg_pkg::CFG_DATA_W-1:0]   cfg_data,
    output lpg_pkg::lpg_cfg_t                cfg_out
);

    logic [11:0] on_duty_reg, on_duty_next;
    logic [27:0] program_map_reg, program_map_next;
    logic [6:0]  bright_sat;
    logic [23:0] on_prod;

    assign cfg_ready = 1'b1;

    always_comb begin
        bright_sat = (cfg_data[6:0] > lpg_pkg::MAX_BRIGHTNESS) ? lpg_pkg::MAX_BRIGHTNESS
                                                              : cfg_data[6:0];
        on_prod          = 24'(bright_sat) * 24'(lpg_pkg::ON_RECIP);
        on_duty_next     = on_duty_reg;
        program_map_next = program_map_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                lpg_pkg::CFG_BRIGHTNESS:  on_duty_next     = on_prod[23:12];
                lpg_pkg::CFG_PROGRAM_MAP: program_map_next = cfg_data[27:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            on_duty_reg     <= lpg_pkg::FULL_DUTY;
            program_map_reg <= lpg_pkg::PROGRAM_MAP_RST;
        end else begin
            on_duty_reg     <= on_duty_next;
            program_map_reg <= program_map_next;
        end
    end

    assign cfg_out.on_duty     = on_duty_reg;
    assign cfg_out.program_map = program_map_reg;

endmodule

// ===== sv/lpg_duty_unit.sv =====
// Shared duty unit: one LED's PWM duty from its pattern code, the phase and the on duty.
// Depends on lpg_pkg.
module lpg_duty_unit (
    input  logic [3:0]  mode,
    input  logic [4:0]  phase,
    input  logic [11:0] on_duty,
    output logic [11:0] duty
);

    logic        lit;
    logic [27:0] breathe_prod;

    always_comb begin
        breathe_prod = 28'(lpg_pkg::sine_lut(phase)) * 28'(on_duty[11:1]);
        unique case (mode)
            lpg_pkg::MODE_ON:        lit = 1'b1;
            lpg_pkg::MODE_BLINK:     lit = !phase[2];
            lpg_pkg::MODE_INV_BLINK: lit = phase[2];
            lpg_pkg::MODE_FAST:      lit = !phase[0];
            lpg_pkg::MODE_SLOW:      lit = (phase < 5'd12);
            lpg_pkg::MODE_DOUBLE:    lit = (phase < 5'd2) || (phase == 5'd4) || (phase == 5'd5);
            lpg_pkg::MODE_TRIPLE:    lit = (phase < 5'd2) || (phase == 5'd4) || (phase == 5'd5)
                                           || (phase == 5'd8) || (phase == 5'd9);
            lpg_pkg::MODE_HEART:     lit = (phase == 5'd0) || (phase == 5'd3);
            lpg_pkg::MODE_STROBE:    lit = !phase[1];
            default:                 lit = 1'b0;
        endcase
        if (mode == lpg_pkg::MODE_BREATHE) begin
            duty = breathe_prod[26:15];
        end else begin
            duty = lit ? on_duty : 12'd0;
        end
    end

endmodule

// ===== sv/lpg_checker.sv =====
// Port-level checker for the LED pattern generator, bound to the top level.
// Depends on lpg_pkg and led_pattern_generator_assert.svh.
`include "led_pattern_generator_assert.svh"

module lpg_checker #(
    parameter int LED_COUNT = lpg_pkg::LED_COUNT_DEF
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input lpg_pkg::lpg_in_t               s_payload,
    input logic                           m_valid,
    input logic                           m_ready,
    input lpg_pkg::lpg_out_t              m_payload
);

    localparam logic [2:0] LAST_LED = 3'(LED_COUNT - 1);

    `LPG_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_payload), "result changed while stalled")

    `LPG_ASSERT_NOW(a_busy_mid_burst, aclk, aresetn, m_valid && !m_payload.last,
        !s_ready, "input ready while a burst is unfinished")

    `LPG_ASSERT_NOW(a_duty_range, aclk, aresetn, m_valid,
        m_payload.duty <= lpg_pkg::FULL_DUTY, "duty above full scale")

    `LPG_ASSERT_NOW(a_last_led, aclk, aresetn, m_valid && !m_payload.last,
        m_payload.led_number != LAST_LED, "final LED result not marked last")

    `LPG_ASSERT_NEXT(a_tick_busy, aclk, aresetn,
        s_valid && s_ready && s_payload.op == lpg_pkg::OP_TICK,
        !s_ready, "tick transfer did not start a burst")

endmodule

bind led_pattern_generator lpg_checker #(.LED_COUNT(LED_COUNT)) u_lpg_checker (.*);
